[design/pdt_pkg.sv]
// Shared types, register indexes and reset values for the periodic task dispatcher.
package pdt_pkg;

  localparam int unsigned NUM_SLOTS  = 3;
  localparam int unsigned SLOT_W     = 2;
  localparam int unsigned TICK_W     = 8;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_REBOOT = 2'd1;
  localparam logic [1:0] MODE_REPORT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_SLOT0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_SLOT1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_SLOT2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_SLOT0   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_SLOT1   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_SLOT2   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OVERRUN_LIMIT = 3'd6;

  localparam logic [TICK_W-1:0] PERIOD_SLOT0_RST  = 8'd2;
  localparam logic [TICK_W-1:0] PERIOD_SLOT12_RST = 8'd20;
  localparam logic [TICK_W-1:0] START_SLOT0_RST   = 8'd2;
  localparam logic [TICK_W-1:0] START_SLOT1_RST   = 8'd3;
  localparam logic [TICK_W-1:0] START_SLOT2_RST   = 8'd4;
  localparam logic [DUR_W-1:0]  OVERRUN_LIMIT_RST = 16'd50;
  localparam logic [TICK_W-1:0] COUNTDOWN_RST     = 8'd255;

  typedef struct packed {
    logic [NUM_SLOTS-1:0][TICK_W-1:0] period;
    logic [NUM_SLOTS-1:0][TICK_W-1:0] start;
    logic [DUR_W-1:0]                 overrun_limit;
  } cfg_regs_t;

  typedef struct packed {
    logic              step;
    logic [TICK_W-1:0] tick;
  } slot_ctrl_t;

endpackage

[design/pdt_if.sv]
// Handshake channel interfaces for the input, result and configuration ports.
interface pdt_in_if import pdt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [TICK_W-1:0] tick_value;
  logic [SLOT_W-1:0] slot_number;
  logic [DUR_W-1:0]  run_duration;
  modport source (output valid, mode, tick_value, slot_number, run_duration, input ready);
  modport sink (input valid, mode, tick_value, slot_number, run_duration, output ready);
endinterface

interface pdt_out_if import pdt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [NUM_SLOTS-1:0] fire_mask;
  logic                 watchdog_kick;
  logic [SLOT_W-1:0]    fault_slot;
  modport source (output valid, fire_mask, watchdog_kick, fault_slot, input ready);
  modport sink (input valid, fire_mask, watchdog_kick, fault_slot, output ready);
endinterface

interface pdt_cfg_if import pdt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/pdt_cfg.sv]
// Configuration register file: slot periods, start ticks and the overrun limit.
module pdt_cfg import pdt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_regs_t             regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_PERIOD_SLOT0:  regs_nxt.period[0]     = wr_data[TICK_W-1:0];
        REG_PERIOD_SLOT1:  regs_nxt.period[1]     = wr_data[TICK_W-1:0];
        REG_PERIOD_SLOT2:  regs_nxt.period[2]     = wr_data[TICK_W-1:0];
        REG_START_SLOT0:   regs_nxt.start[0]      = wr_data[TICK_W-1:0];
        REG_START_SLOT1:   regs_nxt.start[1]      = wr_data[TICK_W-1:0];
        REG_START_SLOT2:   regs_nxt.start[2]      = wr_data[TICK_W-1:0];
        REG_OVERRUN_LIMIT: regs_nxt.overrun_limit = wr_data[DUR_W-1:0];
        default:           regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.period[0]     <= PERIOD_SLOT0_RST;
      regs_r.period[1]     <= PERIOD_SLOT12_RST;
      regs_r.period[2]     <= PERIOD_SLOT12_RST;
      regs_r.start[0]      <= START_SLOT0_RST;
      regs_r.start[1]      <= START_SLOT1_RST;
      regs_r.start[2]      <= START_SLOT2_RST;
      regs_r.overrun_limit <= OVERRUN_LIMIT_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

[design/pdt_slot.sv]
// One task slot: countdown register, reload and fire decision for a tick.
module pdt_slot import pdt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  slot_ctrl_t        ctrl,
  input  logic [TICK_W-1:0] period,
  input  logic [TICK_W-1:0] start,
  output logic              fire
);

  logic [TICK_W-1:0] countdown_r;
  logic [TICK_W-1:0] countdown_nxt;
  logic [TICK_W-1:0] dec;
  logic              enabled;

  always_comb begin
    enabled       = (period != '0);
    dec           = (countdown_r != '0) ? countdown_r - 1'b1 : countdown_r;
    fire          = 1'b0;
    countdown_nxt = countdown_r;
    if (ctrl.step && enabled) begin
      fire          = (dec == '0) || (start == ctrl.tick);
      countdown_nxt = fire ? period : dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      countdown_r <= COUNTDOWN_RST;
    end else begin
      countdown_r <= countdown_nxt;
    end
  end

endmodule

[design/periodic_task_dispatcher_top.sv]
// Top level of the periodic task dispatcher: slots, fault record and result register.
//
// The dispatcher takes one item per clock while its results are taken and
// returns exactly one result per item. An accepted item updates the three
// slot countdowns, the reboot flag and the sticky fault record at the same
// clock edge that loads the result register, so the result appears on the
// out channel in the cycle after the input transfer. The only thing
// that holds off input is the single result register: in_ch.ready is high
// whenever that register is empty or its content is taken in the same cycle.
// Tick items (mode 0, nonzero tick) step every slot whose period is nonzero,
// report the fire mask and refresh the watchdog unless a reboot request has
// been seen since reset. Duration reports for slots 0 to 2 whose run time is
// strictly above the overrun limit record slot plus one as the fault; every
// result carries the fault record as it stands after its item. Configuration
// writes are taken in every cycle (cfg_ch.ready is always high) and should be
// made only while the block is idle; an index of 7 is accepted and ignored.
module periodic_task_dispatcher_top import pdt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  pdt_in_if.sink    in_ch,
  pdt_out_if.source out_ch,
  pdt_cfg_if.sink   cfg_ch
);

  cfg_regs_t            regs;
  slot_ctrl_t           slot_ctrl;
  logic [NUM_SLOTS-1:0] fire;
  logic                 in_xfer;
  logic                 is_tick;

  logic                 out_valid_r;
  logic [NUM_SLOTS-1:0] fire_mask_r;
  logic                 kick_r;
  logic [SLOT_W-1:0]    fault_slot_r;

  logic                 reboot_pending_r;
  logic                 reboot_pending_nxt;
  logic [SLOT_W-1:0]    fault_record_r;
  logic [SLOT_W-1:0]    fault_record_nxt;

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;

  pdt_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .regs     (regs)
  );

  // The result register is free when empty or when it drains this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign is_tick     = (in_ch.mode == MODE_TICK) && (in_ch.tick_value != '0);

  assign slot_ctrl.step = in_xfer && is_tick;
  assign slot_ctrl.tick = in_ch.tick_value;

  for (genvar n = 0; n < NUM_SLOTS; n++) begin : g_slot
    pdt_slot u_slot (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (slot_ctrl),
      .period (regs.period[n]),
      .start  (regs.start[n]),
      .fire   (fire[n])
    );
  end

  // Reboot flag and sticky fault record. Mode 3 and slot 3 reports are ignored.
  always_comb begin
    reboot_pending_nxt = reboot_pending_r;
    fault_record_nxt   = fault_record_r;
    if (in_xfer) begin
      if (in_ch.mode == MODE_REBOOT) begin
        reboot_pending_nxt = 1'b1;
      end
      if ((in_ch.mode == MODE_REPORT) && (in_ch.slot_number < SLOT_W'(NUM_SLOTS))
          && (in_ch.run_duration > regs.overrun_limit)) begin
        fault_record_nxt = in_ch.slot_number + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reboot_pending_r <= 1'b0;
      fault_record_r   <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      reboot_pending_r <= reboot_pending_nxt;
      fault_record_r   <= fault_record_nxt;
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: loaded on every input transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fire_mask_r  <= fire;
      kick_r       <= is_tick && !reboot_pending_r;
      fault_slot_r <= fault_record_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.fire_mask     = fire_mask_r;
  assign out_ch.watchdog_kick = kick_r;
  assign out_ch.fault_slot    = fault_slot_r;

  // Once a reboot has been requested, no later tick refreshes the watchdog.
  a_no_kick_after_reboot: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && reboot_pending_r) |=> !out_ch.watchdog_kick)
    else $error("watchdog kicked after reboot request");

  // Items that are not ticks never fire a slot or kick the watchdog.
  a_non_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !is_tick) |=> (out_ch.fire_mask == '0) && !out_ch.watchdog_kick)
    else $error("non-tick item produced fire or kick");

  // The fault record is sticky: once set it never returns to no fault.
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (fault_record_r != '0) |=> (fault_record_r != '0))
    else $error("fault record cleared");

  // Every input transfer leaves a result waiting in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("input transfer without result");

endmodule
